FILE: hdl/tdds_pkg.sv
// ----------------------------------------------------------------------------
// tdds_pkg
// Shared types, codes, the character classifier and the table index function
// for the table-driven DFA scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package tdds_pkg;

    localparam int STATE_W     = 7;
    localparam int CLASS_W     = 4;
    localparam int CHAR_W      = 8;
    localparam int ENTRY_W     = 8;
    localparam int NUM_CLASSES = 12;
    // Wide enough for any 7-bit state times twelve plus a class.
    localparam int TBL_IDX_W   = 11;
    localparam int CFG_DATA_W  = 32;
    localparam int CFG_ADDR_W  = 3;

    localparam logic [STATE_W-1:0] ERROR_STATE = 7'd99;
    localparam logic [CHAR_W-1:0]  SPACE_CHAR  = 8'd32;

    localparam logic REQ_SCAN  = 1'b0;
    localparam logic REQ_WRITE = 1'b1;

    localparam logic REG_START  = 1'b0;
    localparam logic REG_ACCEPT = 1'b1;

    localparam logic [STATE_W-1:0] START_RESET  = 7'd0;
    localparam logic [STATE_W-1:0] ACCEPT_RESET = 7'd1;

    localparam logic [CLASS_W-1:0] CLASS_WS      = 4'd0;
    localparam logic [CLASS_W-1:0] CLASS_NEWLINE = 4'd1;
    localparam logic [CLASS_W-1:0] CLASS_ALPHA   = 4'd2;
    localparam logic [CLASS_W-1:0] CLASS_ZERO    = 4'd3;
    localparam logic [CLASS_W-1:0] CLASS_OCTAL   = 4'd4;
    localparam logic [CLASS_W-1:0] CLASS_DECIMAL = 4'd5;
    localparam logic [CLASS_W-1:0] CLASS_SLASH   = 4'd6;
    localparam logic [CLASS_W-1:0] CLASS_STAR    = 4'd7;
    localparam logic [CLASS_W-1:0] CLASS_ARITH   = 4'd8;
    localparam logic [CLASS_W-1:0] CLASS_OTHER   = 4'd9;
    localparam logic [CLASS_W-1:0] CLASS_EOF     = 4'd10;
    localparam logic [CLASS_W-1:0] CLASS_ERR     = 4'd11;

    typedef enum logic [1:0] {
        VERDICT_NONE   = 2'd0,
        VERDICT_RECOG  = 2'd1,
        VERDICT_EOF    = 2'd2,
        VERDICT_REJECT = 2'd3
    } verdict_t;

    typedef struct packed {
        logic                 en;
        logic [TBL_IDX_W-1:0] addr;
        logic [ENTRY_W-1:0]   data;
    } tbl_wr_t;

    typedef struct packed {
        logic                 en;
        logic [TBL_IDX_W-1:0] addr;
    } tbl_rd_t;

    function automatic logic [CLASS_W-1:0] classify(input logic [CHAR_W-1:0] ch,
                                                    input logic              eof);
        logic [CLASS_W-1:0] cls;
        cls = CLASS_ERR;
        if (eof)
            cls = CLASS_EOF;
        else if (ch == 8'd32 || ch == 8'd9)
            cls = CLASS_WS;
        else if (ch == 8'd10)
            cls = CLASS_NEWLINE;
        else if ((ch >= 8'd65 && ch <= 8'd90) || ch == 8'd95 ||
                 (ch >= 8'd97 && ch <= 8'd122))
            cls = CLASS_ALPHA;
        else if (ch == 8'd48)
            cls = CLASS_ZERO;
        else if (ch >= 8'd49 && ch <= 8'd55)
            cls = CLASS_OCTAL;
        else if (ch == 8'd56 || ch == 8'd57)
            cls = CLASS_DECIMAL;
        else if (ch == 8'd47)
            cls = CLASS_SLASH;
        else if (ch == 8'd42)
            cls = CLASS_STAR;
        else if (ch == 8'd43 || ch == 8'd45 || ch == 8'd37)
            cls = CLASS_ARITH;
        else if (ch >= 8'd32 && ch <= 8'd127)
            cls = CLASS_OTHER;
        return cls;
    endfunction

    function automatic logic [TBL_IDX_W-1:0] table_index(input logic [STATE_W-1:0] st,
                                                         input logic [CLASS_W-1:0] cls);
        return {1'b0, st, 3'b000} + {2'b00, st, 2'b00} + {7'd0, cls};
    endfunction

endpackage

`default_nettype wire

FILE: hdl/tdds_table.sv
// ----------------------------------------------------------------------------
// tdds_table
// Transition table store: one write port and one read port with a
// registered read that holds its data until the next read.
// ----------------------------------------------------------------------------
`default_nettype none

module tdds_table #(
    parameter int DEPTH = 1536
) (
    input  wire logic                      clk,
    input  wire tdds_pkg::tbl_wr_t         wr,
    input  wire tdds_pkg::tbl_rd_t         rd,
    output logic [tdds_pkg::ENTRY_W-1:0]   rdata
);
    import tdds_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    logic [ENTRY_W-1:0] mem [DEPTH];
    logic [ENTRY_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (wr.en)
        begin
            mem[wr.addr[ADDR_W-1:0]] <= wr.data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd.en)
        begin
            rdata_reg <= mem[rd.addr[ADDR_W-1:0]];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

FILE: hdl/table_driven_dfa_scanner_top.sv
// ----------------------------------------------------------------------------
// table_driven_dfa_scanner_top
// Table-driven lexer: classifies each character, steps the state through
// the stored transition table and streams out saved characters and verdicts.
// ----------------------------------------------------------------------------
// A scan request is registered into s1 with its table read, then into the
// outputs. One request per cycle unless the output stalls; the table read
// data feeds the next state, forming the next read address in that cycle.
// Reset clears the control state and valid flags but not the data registers;
// table contents stay undefined until written, with no clearing pass.
`default_nettype none

module table_driven_dfa_scanner_top #(
    parameter int NUM_STATES = 128
) (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,

    input  wire logic                                 psel,
    input  wire logic                                 penable,
    input  wire logic                                 pwrite,
    input  wire logic [tdds_pkg::CFG_ADDR_W-1:0]      paddr,
    input  wire logic [tdds_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [tdds_pkg::CFG_DATA_W-1:0]           prdata,
    output logic                                      pready,

    input  wire logic                                 in_valid,
    output logic                                      in_ready,
    input  wire logic                                 req_type,
    input  wire logic [tdds_pkg::CHAR_W-1:0]          char_code,
    input  wire logic                                 is_eof,
    input  wire logic [tdds_pkg::STATE_W-1:0]         entry_state,
    input  wire logic [tdds_pkg::CLASS_W-1:0]         entry_class,
    input  wire logic [tdds_pkg::STATE_W-1:0]         entry_next,
    input  wire logic                                 entry_save,

    output logic                                      out_valid,
    input  wire logic                                 out_ready,
    output logic [tdds_pkg::STATE_W-1:0]              prior_state,
    output logic [tdds_pkg::STATE_W-1:0]              new_state,
    output logic [tdds_pkg::CLASS_W-1:0]              char_class,
    output logic                                      save_valid,
    output logic [tdds_pkg::CHAR_W-1:0]               saved_char,
    output logic                                      token_done,
    output logic [1:0]                                verdict,
    output logic                                      skipping
);
    import tdds_pkg::*;

    localparam int DEPTH = NUM_STATES * NUM_CLASSES;

    logic [STATE_W-1:0] start_reg;
    logic [STATE_W-1:0] accept_reg;
    logic [STATE_W-1:0] cur_state_reg;
    logic [STATE_W-1:0] cur_state_next;
    logic               skip_reg;
    logic               skip_next;

    logic               s1_valid_reg;
    logic [CLASS_W-1:0] s1_class_reg;
    logic [CHAR_W-1:0]  s1_char_reg;
    logic               s1_eof_reg;
    logic [STATE_W-1:0] s1_prior_reg;
    logic               s1_skip_reg;
    logic               s1_oob_reg;

    logic [ENTRY_W-1:0] tbl_rdata;
    logic [ENTRY_W-1:0] s1_entry;
    logic [STATE_W-1:0] s1_new_state;
    logic               s1_new_skip;
    logic               s1_save;
    logic               s1_done;
    verdict_t           s1_verdict;

    logic               out_valid_reg;
    logic [STATE_W-1:0] out_prior_reg;
    logic [STATE_W-1:0] out_new_reg;
    logic [CLASS_W-1:0] out_class_reg;
    logic               out_save_reg;
    logic [CHAR_W-1:0]  out_char_reg;
    logic               out_done_reg;
    verdict_t           out_verdict_reg;
    logic               out_skip_reg;

    logic               cfg_wr;
    logic               out_free;
    logic               s1_move;
    logic               in_fire;
    logic               scan_fire;
    logic [STATE_W-1:0] eff_state;
    logic               eff_skip;
    logic [CLASS_W-1:0] in_class;
    tbl_wr_t            tbl_wr;
    tbl_rd_t            tbl_rd;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb
    begin
        unique case (paddr[2])
            REG_START:  prdata = {{(CFG_DATA_W-STATE_W){1'b0}}, start_reg};
            REG_ACCEPT: prdata = {{(CFG_DATA_W-STATE_W){1'b0}}, accept_reg};
            default:    prdata = '0;
        endcase
    end

    assign out_free  = !out_valid_reg || out_ready;
    assign s1_move   = s1_valid_reg && out_free;
    assign in_ready  = !s1_valid_reg || out_free;
    assign in_fire   = in_valid && in_ready;
    assign scan_fire = in_fire && (req_type == REQ_SCAN);

    // The state seen by a new request is the one its predecessor leaves.
    assign eff_state = s1_valid_reg ? s1_new_state : cur_state_reg;
    assign eff_skip  = s1_valid_reg ? s1_new_skip  : skip_reg;
    assign in_class  = classify(char_code, is_eof);

    always_comb
    begin
        tbl_rd.en   = scan_fire;
        tbl_rd.addr = table_index(eff_state, in_class);
        tbl_wr.en   = in_fire && (req_type == REQ_WRITE) &&
                      ({1'b0, entry_state} < (STATE_W+1)'(NUM_STATES)) &&
                      (entry_class < CLASS_W'(NUM_CLASSES));
        tbl_wr.addr = table_index(entry_state, entry_class);
        tbl_wr.data = {entry_save, entry_next};
    end

    tdds_table #(
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .wr    (tbl_wr),
        .rd    (tbl_rd),
        .rdata (tbl_rdata)
    );

    assign s1_entry = s1_oob_reg ? '0 : tbl_rdata;

    always_comb
    begin
        s1_new_state = s1_prior_reg;
        s1_new_skip  = s1_skip_reg;
        s1_save      = 1'b0;
        s1_done      = 1'b0;
        s1_verdict   = VERDICT_NONE;
        if (s1_skip_reg)
        begin
            if (s1_eof_reg || s1_char_reg == SPACE_CHAR)
            begin
                s1_new_skip  = 1'b0;
                s1_new_state = start_reg;
            end
        end
        else
        begin
            s1_save = !s1_eof_reg && s1_entry[ENTRY_W-1];
            priority if (s1_entry[STATE_W-1:0] == accept_reg)
            begin
                s1_done      = 1'b1;
                s1_verdict   = (s1_class_reg == CLASS_EOF) ? VERDICT_EOF : VERDICT_RECOG;
                s1_new_state = start_reg;
            end
            else if (s1_entry[STATE_W-1:0] == ERROR_STATE)
            begin
                s1_done      = 1'b1;
                s1_verdict   = VERDICT_REJECT;
                s1_new_skip  = 1'b1;
                s1_new_state = start_reg;
            end
            else
            begin
                s1_new_state = s1_entry[STATE_W-1:0];
            end
        end
    end

    always_comb
    begin
        cur_state_next = cur_state_reg;
        skip_next      = skip_reg;
        priority if (cfg_wr && paddr[2] == REG_START)
        begin
            cur_state_next = pwdata[STATE_W-1:0];
        end
        else if (s1_move)
        begin
            cur_state_next = s1_new_state;
            skip_next      = s1_new_skip;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg     <= START_RESET;
            accept_reg    <= ACCEPT_RESET;
            cur_state_reg <= START_RESET;
            skip_reg      <= 1'b0;
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_START)
            begin
                start_reg <= pwdata[STATE_W-1:0];
            end
            if (cfg_wr && paddr[2] == REG_ACCEPT)
            begin
                accept_reg <= pwdata[STATE_W-1:0];
            end
            cur_state_reg <= cur_state_next;
            skip_reg      <= skip_next;
            if (in_ready)
            begin
                s1_valid_reg <= scan_fire;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_fire)
        begin
            s1_class_reg <= in_class;
            s1_char_reg  <= char_code;
            s1_eof_reg   <= is_eof;
            s1_prior_reg <= eff_state;
            s1_skip_reg  <= eff_skip;
            s1_oob_reg   <= ({1'b0, eff_state} >= (STATE_W+1)'(NUM_STATES));
        end
        if (s1_move)
        begin
            out_prior_reg   <= s1_prior_reg;
            out_new_reg     <= s1_new_state;
            out_class_reg   <= s1_class_reg;
            out_save_reg    <= s1_save;
            out_char_reg    <= s1_save ? s1_char_reg : '0;
            out_done_reg    <= s1_done;
            out_verdict_reg <= s1_verdict;
            out_skip_reg    <= s1_skip_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign prior_state = out_prior_reg;
    assign new_state   = out_new_reg;
    assign char_class  = out_class_reg;
    assign save_valid  = out_save_reg;
    assign saved_char  = out_char_reg;
    assign token_done  = out_done_reg;
    assign verdict     = out_verdict_reg;
    assign skipping    = out_skip_reg;

endmodule

`default_nettype wire
